FILE: design/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
// Used by cft_step, cft_queue and csv_field_tokenizer_top; depends on nothing.
package cft_pkg;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOT  = 1'b1;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // Result queue depth; an item is processed only while two slots are free.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       unclosed_quote;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

FILE: design/cft_step.sv
// Tokenizer flags and the per-item decode: one item in, up to two results out.
// Depends on cft_pkg.
module cft_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  cft_pkg::item_t  item,
  input  logic [7:0]      delimiter,
  output cft_pkg::push_t  push
);

  logic in_q_r, q_pend_r, cr_pend_r, row_st_r;
  logic in_q_nxt, q_pend_nxt, cr_pend_nxt, row_st_nxt;

  always_comb begin
    logic           iq, qp, crp, rs, done;
    logic [1:0]     n;
    logic [7:0]     c;
    cft_pkg::res_t  r [2];
    iq   = in_q_r;
    qp   = q_pend_r;
    crp  = cr_pend_r;
    rs   = row_st_r;
    done = 1'b0;
    n    = 2'd0;
    c    = item.text_byte;
    r[0] = '0;
    r[1] = '0;
    if (item.action == cft_pkg::ACT_EOT) begin
      if (crp) begin
        if (rs) begin
          r[n[0]] = '{cft_pkg::KIND_ROW, 8'd0, 1'b0, 1'b0};
          n = n + 2'd1;
        end
      end else if (iq) begin
        r[n[0]] = '{cft_pkg::KIND_ROW, 8'd0, 1'b1, 1'b0};
        n = n + 2'd1;
      end else if (rs) begin
        r[n[0]] = '{cft_pkg::KIND_ROW, 8'd0, 1'b0, 1'b0};
        n = n + 2'd1;
      end
      iq  = 1'b0;
      qp  = 1'b0;
      crp = 1'b0;
      rs  = 1'b0;
    end else begin
      // Resolve a pending CR first: CRLF ends the row, else the CR ends a field.
      if (crp) begin
        crp = 1'b0;
        if (c == cft_pkg::CH_LF) begin
          if (rs) begin
            r[n[0]] = '{cft_pkg::KIND_ROW, 8'd0, 1'b0, 1'b0};
            n = n + 2'd1;
          end
          rs   = 1'b0;
          done = 1'b1;
        end else begin
          r[n[0]] = '{cft_pkg::KIND_FIELD, 8'd0, 1'b0, 1'b0};
          n  = n + 2'd1;
          rs = 1'b1;
        end
      end
      // Quote right after a closing quote: literal quote, reopen quoting.
      if (!done && qp) begin
        qp = 1'b0;
        if (c == cft_pkg::CH_QUOTE) begin
          iq = 1'b1;
          rs = 1'b1;
          r[n[0]] = '{cft_pkg::KIND_DATA, c, 1'b0, 1'b0};
          n    = n + 2'd1;
          done = 1'b1;
        end
      end
      if (!done && iq) begin
        rs = 1'b1;
        if (c == cft_pkg::CH_QUOTE) begin
          iq = 1'b0;
          qp = 1'b1;
        end else begin
          r[n[0]] = '{cft_pkg::KIND_DATA, c, 1'b0, 1'b0};
          n = n + 2'd1;
        end
        done = 1'b1;
      end
      if (!done) begin
        if (c == cft_pkg::CH_QUOTE) begin
          iq = 1'b1;
          rs = 1'b1;
        end else if (c == delimiter) begin
          r[n[0]] = '{cft_pkg::KIND_FIELD, 8'd0, 1'b0, 1'b0};
          n  = n + 2'd1;
          rs = 1'b1;
        end else if (c == cft_pkg::CH_LF) begin
          if (rs) begin
            r[n[0]] = '{cft_pkg::KIND_ROW, 8'd0, 1'b0, 1'b0};
            n = n + 2'd1;
          end
          rs = 1'b0;
        end else if (c == cft_pkg::CH_CR) begin
          crp = 1'b1;
        end else begin
          r[n[0]] = '{cft_pkg::KIND_DATA, c, 1'b0, 1'b0};
          n  = n + 2'd1;
          rs = 1'b1;
        end
      end
    end
    // Mark the final result of this item.
    if (n == 2'd2) begin
      r[1].last = 1'b1;
    end else if (n == 2'd1) begin
      r[0].last = 1'b1;
    end
    in_q_nxt    = iq;
    q_pend_nxt  = qp;
    cr_pend_nxt = crp;
    row_st_nxt  = rs;
    push.num    = adv ? n : 2'd0;
    push.res0   = r[0];
    push.res1   = r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_r    <= 1'b0;
      q_pend_r  <= 1'b0;
      cr_pend_r <= 1'b0;
      row_st_r  <= 1'b0;
    end else if (adv) begin
      in_q_r    <= in_q_nxt;
      q_pend_r  <= q_pend_nxt;
      cr_pend_r <= cr_pend_nxt;
      row_st_r  <= row_st_nxt;
    end
  end

endmodule

FILE: design/cft_queue.sv
// Result queue: takes up to two results a cycle, hands out one.
// Depends on cft_pkg.
module cft_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cft_pkg::push_t  push,
  output logic            room2,
  output logic            out_valid,
  input  logic            out_stall,
  output cft_pkg::res_t   head
);

  cft_pkg::res_t                mem_r [cft_pkg::QDEPTH];
  logic [cft_pkg::QPTR_W-1:0]   wp_r, rp_r, wp_nxt, rp_nxt;
  logic [cft_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         pop;

  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (cnt_r <= cft_pkg::QCNT_W'(cft_pkg::QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + cft_pkg::QPTR_W'(push.num);
    rp_nxt  = rp_r + cft_pkg::QPTR_W'(pop);
    cnt_nxt = cnt_r + cft_pkg::QCNT_W'(push.num) - cft_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem_r[wp_r + cft_pkg::QPTR_W'(1)] <= push.res1;
    end
  end

endmodule

FILE: design/csv_field_tokenizer_top.sv
// Top level of the CSV field tokenizer: input register, config register,
// decode stage and result queue. Depends on cft_pkg, cft_step, cft_queue.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per accepted edge, either
//   a text byte (in_action = byte) or end of text, which closes the open row.
//   Result channel (out_valid / out_stall): field data bytes, field ends and
//   row ends, in text order; out_last marks the final result of an item.
//   Items that cause no result (quotes, a pending CR, an empty row end)
//   produce nothing on the result channel.
//   cfg_we / cfg_wdata write the delimiter; write it only while idle.
// Path: an accepted item is held in the input register, decoded by cft_step
//   and its results are written into the result queue, whose head is the output.
// Throughput: one item per cycle while each item gives at most one result
//   and the receiver keeps up. An item with two results (CR resolved as a
//   field end plus the next byte) needs a second output slot, as the
//   single-result output port drains the four-entry result queue.
// Reset: synchronous, active low; clears all tokenizer flags, empties the
//   queue and sets the delimiter back to a comma.
// Stall: while out_stall is high the queue fills; once fewer than two slots
//   are free the decode stage holds its item and in_stall rises.
module csv_field_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_unclosed_quote,
  output logic       out_last
);

  logic [7:0]      delim_r;
  logic            item_vld_r;
  cft_pkg::item_t  item_r;
  logic            room2;
  logic            adv;
  cft_pkg::push_t  push;
  cft_pkg::res_t   head;

  // Advance the held item only when the queue can take both its results.
  assign adv      = item_vld_r && room2;
  assign in_stall = item_vld_r && !room2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= cft_pkg::DELIM_RESET;
    end else if (cfg_we) begin
      delim_r <= cfg_wdata;
    end
  end

  // Input register: load whenever the held item leaves or none is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.action    <= in_action;
      item_r.text_byte <= in_text_byte;
    end
  end

  cft_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (item_r),
    .delimiter (delim_r),
    .push      (push)
  );

  cft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind           = head.kind;
  assign out_data_byte      = head.data_byte;
  assign out_unclosed_quote = head.unclosed_quote;
  assign out_last           = head.last;

endmodule
